// File: src/tcw_pkg.sv
// tcw_pkg: types and fixed constants of the text console writer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned COL_W      = 7;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned ADDR_IN_W  = 11;
  localparam int unsigned LIN_W      = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  localparam logic [ROW_W-1:0] MIN_ROWS = 5'd4;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_COLOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH   = 3'd5;

  localparam logic [COL_W-1:0]   RST_COLUMNS     = 7'd80;
  localparam logic [ROW_W-1:0]   RST_ROWS        = 5'd25;
  localparam logic [COLOR_W-1:0] RST_FORE_COLOR  = 4'd15;
  localparam logic [COLOR_W-1:0] RST_BACK_COLOR  = 4'd0;
  localparam logic [COLOR_W-1:0] RST_CLEAR_COLOR = 4'd0;
  localparam logic [COLOR_W-1:0] RST_TAB_WIDTH   = 4'd4;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_TAB,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CHAR_W-1:0]    char_code;
    logic [ADDR_IN_W-1:0] cell_address;
  } tcw_in_t;

  typedef struct packed {
    logic [ADDR_IN_W-1:0] cursor_index;
    logic [CELL_W-1:0]    read_data;
    logic                 scrolled;
  } tcw_out_t;

  typedef struct packed {
    op_t                  op;
    logic [CHAR_W-1:0]    char_code;
    logic [ADDR_IN_W-1:0] cell_address;
  } tcw_item_t;

  typedef struct packed {
    logic [COL_W-1:0]   columns;
    logic [ROW_W-1:0]   rows;
    logic [COLOR_W-1:0] fore_color;
    logic [COLOR_W-1:0] back_color;
    logic [COLOR_W-1:0] clear_color;
    logic [COLOR_W-1:0] tab_width;
  } tcw_cfg_t;

  typedef struct packed {
    logic idle;
    logic walking;
  } tcw_status_t;

endpackage

// File: src/text_console_writer.sv
// text_console_writer: text console with cursor, scrolling and cell store
// put, newline, tab and read run exec then done; backspace adds a blanking write except
// at the origin; clear writes every screen cell and a scroll moves the kept cells up and
// blanks freed rows, both bound by the single cell memory write port; a two word queue takes input
// reset clears cursor, queue, sequencer and registers; cell contents stay undefined
`timescale 1ns / 1ps

module text_console_writer #(
  parameter int unsigned MAX_COLS    = 80,
  parameter int unsigned MAX_ROWS    = 25,
  parameter int unsigned SCROLL_ROWS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tcw_pkg::tcw_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tcw_pkg::tcw_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tcw_pkg::tcw_cfg_t    cfg_r;
  logic                 q_valid;
  logic                 q_pop;
  tcw_pkg::tcw_item_t   q_item;
  tcw_pkg::tcw_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns     <= tcw_pkg::RST_COLUMNS;
      cfg_r.rows        <= tcw_pkg::RST_ROWS;
      cfg_r.fore_color  <= tcw_pkg::RST_FORE_COLOR;
      cfg_r.back_color  <= tcw_pkg::RST_BACK_COLOR;
      cfg_r.clear_color <= tcw_pkg::RST_CLEAR_COLOR;
      cfg_r.tab_width   <= tcw_pkg::RST_TAB_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcw_pkg::REG_COLUMNS:     cfg_r.columns     <= cfg_data[6:0];
        tcw_pkg::REG_ROWS:        cfg_r.rows        <= cfg_data[4:0];
        tcw_pkg::REG_FORE_COLOR:  cfg_r.fore_color  <= cfg_data[3:0];
        tcw_pkg::REG_BACK_COLOR:  cfg_r.back_color  <= cfg_data[3:0];
        tcw_pkg::REG_CLEAR_COLOR: cfg_r.clear_color <= cfg_data[3:0];
        tcw_pkg::REG_TAB_WIDTH:   cfg_r.tab_width   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  tcw_back #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .SCROLL_ROWS (SCROLL_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  a_pop_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && status.idle))
    else $error("word taken from queue while sequencer busy or queue empty");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_valid)
    else $error("input stalled with empty queue");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(status.idle))
    else $error("result appeared without an operation in progress");

  a_walk_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    status.walking |=> !$rose(out_valid))
    else $error("result raised straight out of a memory walk");

endmodule

// File: src/tcw_front.sv
// tcw_front: accepts input words, decodes them into operations and queues them
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::tcw_in_t   in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output tcw_pkg::tcw_item_t q_item
);

  tcw_pkg::tcw_item_t               q_r [tcw_pkg::Q_DEPTH];
  logic [tcw_pkg::Q_PTR_W-1:0]      wr_ptr_r;
  logic [tcw_pkg::Q_PTR_W-1:0]      rd_ptr_r;
  logic [tcw_pkg::Q_CNT_W-1:0]      cnt_r;
  logic [tcw_pkg::Q_CNT_W-1:0]      cnt_nxt;
  logic                             push;
  tcw_pkg::tcw_item_t               decoded;

  assign in_stall = (cnt_r == tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    decoded.char_code    = in_data.char_code;
    decoded.cell_address = in_data.cell_address;
    case (in_data.kind)
      tcw_pkg::KIND_PUT: begin
        case (in_data.char_code)
          tcw_pkg::CH_NEWLINE:   decoded.op = tcw_pkg::OP_NEWLINE;
          tcw_pkg::CH_TAB:       decoded.op = tcw_pkg::OP_TAB;
          tcw_pkg::CH_BACKSPACE: decoded.op = tcw_pkg::OP_BACKSPACE;
          default:               decoded.op = tcw_pkg::OP_CHAR;
        endcase
      end
      tcw_pkg::KIND_CLEAR: decoded.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::KIND_READ:  decoded.op = tcw_pkg::OP_READ;
      default:             decoded.op = tcw_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

// File: src/tcw_back.sv
// tcw_back: cursor, character cell memory and the sequencer that runs each operation
// depends on tcw_pkg; fed from tcw_front, drives the result register
`timescale 1ns / 1ps

module tcw_back #(
  parameter int unsigned MAX_COLS    = 80,
  parameter int unsigned MAX_ROWS    = 25,
  parameter int unsigned SCROLL_ROWS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcw_pkg::tcw_cfg_t    cfg,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  tcw_pkg::tcw_item_t   q_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcw_pkg::tcw_out_t    out_data,
  output tcw_pkg::tcw_status_t status
);

  localparam int unsigned CELLS  = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_BSWR = 6'b000100,
    ST_MOVE = 6'b001000,
    ST_FILL = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0] mem_q_r;

  state_t                          st_r, st_nxt;
  tcw_pkg::tcw_item_t              item_r;
  logic [tcw_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic                            scrolled_r, scrolled_nxt;
  logic [tcw_pkg::LIN_W-1:0]       total_r;
  logic [tcw_pkg::LIN_W-1:0]       shift_r;
  logic [tcw_pkg::LIN_W-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic                            pend_r, pend_nxt;
  logic [ADDR_W-1:0]               dst_r, dst_nxt;
  logic [tcw_pkg::LIN_W-1:0]       fill_ptr_r, fill_ptr_nxt;
  logic [tcw_pkg::CELL_W-1:0]      fill_data_r, fill_data_nxt;
  logic                            out_valid_r;
  tcw_pkg::tcw_out_t               out_data_r;

  logic [tcw_pkg::COL_W-1:0]       nc;
  logic [tcw_pkg::ROW_W-1:0]       nr;
  logic [tcw_pkg::LIN_W-1:0]       idx;
  logic [tcw_pkg::LIN_W-1:0]       keep;
  logic [tcw_pkg::COL_W:0]         col_step;
  logic [tcw_pkg::COL_W:0]         col_tab;
  logic                            row_inc;
  logic                            addr_ok;
  logic                            out_free;
  logic                            we;
  logic [ADDR_W-1:0]               waddr;
  logic [tcw_pkg::CELL_W-1:0]      wdata;
  logic                            rd_en;
  logic [ADDR_W-1:0]               rd_addr;
  logic [tcw_pkg::CELL_W-1:0]      rdata;

  // effective screen size
  always_comb begin
    if (cfg.columns == '0) begin
      nc = 7'd1;
    end else if (int'(cfg.columns) > int'(MAX_COLS)) begin
      nc = tcw_pkg::COL_W'(MAX_COLS);
    end else begin
      nc = cfg.columns;
    end
    if (cfg.rows < tcw_pkg::MIN_ROWS) begin
      nr = tcw_pkg::MIN_ROWS;
    end else if (int'(cfg.rows) > int'(MAX_ROWS)) begin
      nr = tcw_pkg::ROW_W'(MAX_ROWS);
    end else begin
      nr = cfg.rows;
    end
  end

  assign idx      = tcw_pkg::LIN_W'(row_r) * tcw_pkg::LIN_W'(nc) + tcw_pkg::LIN_W'(col_r);
  assign keep     = total_r - shift_r;
  assign col_step = {1'b0, col_r} + 8'd1;
  assign col_tab  = {1'b0, col_r} + {4'd0, cfg.tab_width};
  assign addr_ok  = int'(item_r.cell_address) < int'(CELLS);
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (st_r == ST_IDLE) && q_valid;
  assign rdata    = ((item_r.op == tcw_pkg::OP_READ) && addr_ok) ? mem_q_r : '0;

  always_comb begin
    st_nxt        = st_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    scrolled_nxt  = scrolled_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_nxt      = pend_r;
    dst_nxt       = dst_r;
    fill_ptr_nxt  = fill_ptr_r;
    fill_data_nxt = fill_data_r;
    row_inc       = 1'b0;
    we            = 1'b0;
    waddr         = ADDR_W'(idx);
    wdata         = fill_data_r;
    rd_en         = 1'b0;
    rd_addr       = ADDR_W'(item_r.cell_address);
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          // pull a cursor left over from a larger screen back inside
          if (col_r >= nc) begin
            col_nxt = nc - 7'd1;
          end
          if (row_r >= nr) begin
            row_nxt = nr - 5'd1;
          end
          scrolled_nxt = 1'b0;
          st_nxt       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        st_nxt = ST_DONE;
        case (item_r.op)
          tcw_pkg::OP_CHAR: begin
            we    = 1'b1;
            wdata = {cfg.back_color, cfg.fore_color, item_r.char_code};
            if (col_step >= {1'b0, nc}) begin
              col_nxt = '0;
              row_inc = 1'b1;
            end else begin
              col_nxt = col_step[tcw_pkg::COL_W-1:0];
            end
          end
          tcw_pkg::OP_NEWLINE: begin
            col_nxt = '0;
            row_inc = 1'b1;
          end
          tcw_pkg::OP_TAB: begin
            if (col_tab >= {1'b0, nc}) begin
              col_nxt = '0;
              row_inc = 1'b1;
            end else begin
              col_nxt = col_tab[tcw_pkg::COL_W-1:0];
            end
          end
          tcw_pkg::OP_BACKSPACE: begin
            if (col_r != '0) begin
              col_nxt = col_r - 7'd1;
              st_nxt  = ST_BSWR;
            end else if (row_r != '0) begin
              row_nxt = row_r - 5'd1;
              col_nxt = nc - 7'd1;
              st_nxt  = ST_BSWR;
            end
          end
          tcw_pkg::OP_CLEAR: begin
            col_nxt       = '0;
            row_nxt       = '0;
            fill_ptr_nxt  = '0;
            fill_data_nxt = {cfg.clear_color, 12'd0};
            st_nxt        = ST_FILL;
          end
          tcw_pkg::OP_READ: begin
            rd_en = addr_ok;
          end
          default: begin
            st_nxt = ST_DONE;
          end
        endcase
        if (row_inc) begin
          if ((row_r + 5'd1) >= nr) begin
            row_nxt      = nr - tcw_pkg::ROW_W'(SCROLL_ROWS);
            scrolled_nxt = 1'b1;
            rd_cnt_nxt   = '0;
            pend_nxt     = 1'b0;
            st_nxt       = ST_MOVE;
          end else begin
            row_nxt = row_r + 5'd1;
          end
        end
      end
      ST_BSWR: begin
        we     = 1'b1;
        wdata  = {cfg.back_color, cfg.fore_color, tcw_pkg::CH_SPACE};
        st_nxt = ST_DONE;
      end
      ST_MOVE: begin
        // read the cell SCROLL_ROWS rows further down, write the word read last cycle
        if (rd_cnt_r < keep) begin
          rd_en      = 1'b1;
          rd_addr    = ADDR_W'(rd_cnt_r + shift_r);
          dst_nxt    = ADDR_W'(rd_cnt_r);
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          we    = 1'b1;
          waddr = dst_r;
          wdata = mem_q_r;
        end
        if ((rd_cnt_r >= keep) && !pend_r) begin
          fill_ptr_nxt  = keep;
          fill_data_nxt = {cfg.clear_color, cfg.clear_color, tcw_pkg::CH_SPACE};
          st_nxt        = ST_FILL;
        end
      end
      ST_FILL: begin
        we           = 1'b1;
        waddr        = ADDR_W'(fill_ptr_r);
        fill_ptr_nxt = fill_ptr_r + 1'b1;
        if ((fill_ptr_r + 1'b1) >= total_r) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      if ((st_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scrolled_r  <= scrolled_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    dst_r       <= dst_nxt;
    fill_ptr_r  <= fill_ptr_nxt;
    fill_data_r <= fill_data_nxt;
    if (q_pop) begin
      item_r  <= q_item;
      total_r <= tcw_pkg::LIN_W'(nr) * tcw_pkg::LIN_W'(nc);
      shift_r <= tcw_pkg::LIN_W'(nc) * tcw_pkg::LIN_W'(SCROLL_ROWS);
    end
    if ((st_r == ST_DONE) && out_free) begin
      out_data_r.cursor_index <= idx[tcw_pkg::ADDR_IN_W-1:0];
      out_data_r.read_data    <= rdata;
      out_data_r.scrolled     <= scrolled_r;
    end
  end

  // cell memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign status.idle    = (st_r == ST_IDLE);
  assign status.walking = (st_r == ST_MOVE) || (st_r == ST_FILL);

endmodule

// File: verif/text_console_writer_check.sv
// text_console_writer_check: tracks the console screen and cursor from the words seen
// on the input and register channels, and compares each output word with its prediction
// depends on tcw_pkg; instantiated beside the block by text_console_writer_test
`timescale 1ns / 1ps

module text_console_writer_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  tcw_pkg::tcw_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  tcw_pkg::tcw_out_t              out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_reports,
  output int                             checked_count
);

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int SCROLL_BY   = 3;
  localparam int STORE_CELLS = SCREEN_COLS * SCREEN_ROWS;

  logic [tcw_pkg::CELL_W-1:0]  screen [0:STORE_CELLS-1];
  int                          cur_col;
  int                          cur_row;
  logic [tcw_pkg::COL_W-1:0]   columns;
  logic [tcw_pkg::ROW_W-1:0]   rows;
  logic [tcw_pkg::COLOR_W-1:0] fore_color;
  logic [tcw_pkg::COLOR_W-1:0] back_color;
  logic [tcw_pkg::COLOR_W-1:0] clear_color;
  logic [tcw_pkg::COLOR_W-1:0] tab_width;
  tcw_pkg::tcw_out_t           due_reports [$];
  tcw_pkg::tcw_out_t           predicted;
  tcw_pkg::tcw_out_t           seen;

  function automatic int cols_in_use();
    if (int'(columns) < 1) return 1;
    if (int'(columns) > SCREEN_COLS) return SCREEN_COLS;
    return int'(columns);
  endfunction

  function automatic int rows_in_use();
    if (rows < tcw_pkg::MIN_ROWS) return int'(tcw_pkg::MIN_ROWS);
    if (int'(rows) > SCREEN_ROWS) return SCREEN_ROWS;
    return int'(rows);
  endfunction

  // advances the console by one input word and returns the report it should give
  task automatic step_console(input tcw_pkg::tcw_in_t w, output tcw_pkg::tcw_out_t rep);
    int                         nc;
    int                         nr;
    int                         keep;
    logic [tcw_pkg::CELL_W-1:0] rdata;
    logic                       scr;
    nc    = cols_in_use();
    nr    = rows_in_use();
    rdata = '0;
    scr   = 1'b0;
    if (cur_col >= nc) cur_col = nc - 1;
    if (cur_row >= nr) cur_row = nr - 1;
    case (w.kind)
      tcw_pkg::KIND_PUT: begin
        if (w.char_code == tcw_pkg::CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (w.char_code == tcw_pkg::CH_TAB) begin
          cur_col += int'(tab_width);
          if (cur_col >= nc) begin
            cur_col = 0;
            cur_row++;
          end
        end else if (w.char_code == tcw_pkg::CH_BACKSPACE) begin
          if (cur_col > 0 || cur_row > 0) begin
            if (cur_col > 0) begin
              cur_col--;
            end else begin
              cur_row--;
              cur_col = nc - 1;
            end
            screen[cur_row * nc + cur_col] = {back_color, fore_color, tcw_pkg::CH_SPACE};
          end
        end else begin
          screen[cur_row * nc + cur_col] = {back_color, fore_color, w.char_code};
          cur_col++;
          if (cur_col >= nc) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // row ran off the bottom: shift up and blank the freed rows
        if (cur_row >= nr) begin
          keep = nc * (nr - SCROLL_BY);
          for (int i = 0; i < keep; i++) screen[i] = screen[i + nc * SCROLL_BY];
          for (int i = keep; i < nc * nr; i++) begin
            screen[i] = {clear_color, clear_color, tcw_pkg::CH_SPACE};
          end
          cur_row = nr - SCROLL_BY;
          scr     = 1'b1;
        end
      end
      tcw_pkg::KIND_CLEAR: begin
        for (int i = 0; i < nc * nr; i++) screen[i] = {clear_color, 12'h000};
        cur_col = 0;
        cur_row = 0;
      end
      tcw_pkg::KIND_READ: begin
        if (int'(w.cell_address) < STORE_CELLS) rdata = screen[w.cell_address];
      end
      default: ;
    endcase
    rep.cursor_index = tcw_pkg::ADDR_IN_W'(cur_col + cur_row * nc);
    rep.read_data    = rdata;
    rep.scrolled     = scr;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_col     = 0;
      cur_row     = 0;
      columns     = tcw_pkg::RST_COLUMNS;
      rows        = tcw_pkg::RST_ROWS;
      fore_color  = tcw_pkg::RST_FORE_COLOR;
      back_color  = tcw_pkg::RST_BACK_COLOR;
      clear_color = tcw_pkg::RST_CLEAR_COLOR;
      tab_width   = tcw_pkg::RST_TAB_WIDTH;
      for (int i = 0; i < STORE_CELLS; i++) screen[i] = '0;
      due_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcw_pkg::REG_COLUMNS:     columns     = cfg_data[tcw_pkg::COL_W-1:0];
          tcw_pkg::REG_ROWS:        rows        = cfg_data[tcw_pkg::ROW_W-1:0];
          tcw_pkg::REG_FORE_COLOR:  fore_color  = cfg_data[tcw_pkg::COLOR_W-1:0];
          tcw_pkg::REG_BACK_COLOR:  back_color  = cfg_data[tcw_pkg::COLOR_W-1:0];
          tcw_pkg::REG_CLEAR_COLOR: clear_color = cfg_data[tcw_pkg::COLOR_W-1:0];
          tcw_pkg::REG_TAB_WIDTH:   tab_width   = cfg_data[tcw_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        step_console(in_data, predicted);
        due_reports.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        seen = out_data;
        if (due_reports.size() == 0) begin
          $error("output word with nothing outstanding: cursor_index %0d", seen.cursor_index);
          fail_count++;
        end else begin
          predicted = due_reports.pop_front();
          checked_count++;
          if (seen.cursor_index !== predicted.cursor_index) begin
            $error("cursor_index: expected %0d, got %0d",
                   predicted.cursor_index, seen.cursor_index);
            fail_count++;
          end
          if (seen.read_data !== predicted.read_data) begin
            $error("read_data: expected %h, got %h", predicted.read_data, seen.read_data);
            fail_count++;
          end
          if (seen.scrolled !== predicted.scrolled) begin
            $error("scrolled: expected %b, got %b", predicted.scrolled, seen.scrolled);
            fail_count++;
          end
        end
      end
    end
    pending_reports = due_reports.size();
  end

endmodule

// File: verif/text_console_writer_test.sv
// text_console_writer_test: clock, reset and stimulus for the text console writer
// directed words, then random words over several register settings and idling patterns
// depends on tcw_pkg, text_console_writer and text_console_writer_check
`timescale 1ns / 1ps

module text_console_writer_test;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         QUIET_LIMIT  = 20000;
  localparam int         WALK_SETTLE  = 2010;
  localparam int         PHASES       = 8;
  localparam int         PHASE_WORDS  = 190;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  tcw_pkg::tcw_in_t               in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tcw_pkg::tcw_out_t              out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending_reports;
  int checked_count;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int words_sent    = 0;
  int settings_done = 0;
  int screen_cells  = 2000;

  always #2 clk = ~clk;

  text_console_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  text_console_writer_check console_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_reports (pending_reports),
    .checked_count   (checked_count)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // no handshake on any channel for too long means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tcw_pkg::tcw_in_t make_word(logic [1:0] kind,
                                                 logic [tcw_pkg::CHAR_W-1:0] ch,
                                                 logic [tcw_pkg::ADDR_IN_W-1:0] addr);
    tcw_pkg::tcw_in_t w;
    w.kind         = kind;
    w.char_code    = ch;
    w.cell_address = addr;
    return w;
  endfunction

  // entered and left at a falling edge; valid stays high for a following word
  task automatic send_word(input tcw_pkg::tcw_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic put_char(input logic [tcw_pkg::CHAR_W-1:0] ch);
    send_word(make_word(tcw_pkg::KIND_PUT, ch, tcw_pkg::ADDR_IN_W'($urandom_range(2047))));
  endtask

  task automatic read_cell(input int addr);
    send_word(make_word(tcw_pkg::KIND_READ, tcw_pkg::CHAR_W'($urandom_range(255)),
                        tcw_pkg::ADDR_IN_W'(addr)));
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_reports != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tcw_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= tcw_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_settings(input int cols, input int nrows, input int fg, input int bg,
                               input int clr, input int tab);
    int c_used;
    int r_used;
    drain(WALK_SETTLE);
    write_reg(tcw_pkg::REG_COLUMNS, cols);
    write_reg(tcw_pkg::REG_ROWS, nrows);
    write_reg(tcw_pkg::REG_FORE_COLOR, fg);
    write_reg(tcw_pkg::REG_BACK_COLOR, bg);
    write_reg(tcw_pkg::REG_CLEAR_COLOR, clr);
    write_reg(tcw_pkg::REG_TAB_WIDTH, tab);
    cfg_valid <= 1'b0;
    c_used = (cols < 1) ? 1 : ((cols > 80) ? 80 : cols);
    r_used = (nrows < 4) ? 4 : ((nrows > 25) ? 25 : nrows);
    screen_cells = c_used * r_used;
    settings_done++;
  endtask

  task automatic random_word();
    int pick;
    int sel;
    pick = $urandom_range(99);
    if (pick < 70) begin
      sel = $urandom_range(99);
      if (sel < 12) put_char(tcw_pkg::CH_NEWLINE);
      else if (sel < 20) put_char(tcw_pkg::CH_TAB);
      else if (sel < 32) put_char(tcw_pkg::CH_BACKSPACE);
      else put_char(tcw_pkg::CHAR_W'($urandom_range(255)));
    end else if (pick < 72) begin
      send_word(make_word(tcw_pkg::KIND_CLEAR, tcw_pkg::CHAR_W'($urandom_range(255)),
                          tcw_pkg::ADDR_IN_W'($urandom_range(2047))));
    end else if (pick < 95) begin
      if ($urandom_range(1)) read_cell($urandom_range(2047));
      else read_cell($urandom_range(screen_cells - 1));
    end else begin
      send_word(make_word(KIND_UNUSED, tcw_pkg::CHAR_W'($urandom_range(255)),
                          tcw_pkg::ADDR_IN_W'($urandom_range(2047))));
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: clear first so every cell is written before any read
    send_word(make_word(tcw_pkg::KIND_CLEAR, 8'h00, 11'd0));
    read_cell(0);
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    read_cell(1);
    put_char(tcw_pkg::CH_TAB);
    put_char(tcw_pkg::CH_BACKSPACE);
    put_char(tcw_pkg::CH_NEWLINE);
    put_char(tcw_pkg::CH_BACKSPACE);
    read_cell(79);
    send_word(make_word(KIND_UNUSED, 8'hFF, 11'h7FF));
    read_cell(2047);
    read_cell(1999);
    read_cell(2000);

    // tiny screen: cursor pulled inside, wrap into a scroll, backspace across rows
    load_settings(4, 4, 3, 12, 5, 3);
    put_char(tcw_pkg::CH_TAB);
    put_char(tcw_pkg::CH_NEWLINE);
    put_char(tcw_pkg::CH_NEWLINE);
    repeat (4) put_char(8'h7E);
    read_cell(0);
    read_cell(15);
    put_char(tcw_pkg::CH_BACKSPACE);
    send_word(make_word(tcw_pkg::KIND_CLEAR, 8'hFF, 11'h7FF));
    put_char(tcw_pkg::CH_BACKSPACE);
    read_cell(0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_settings(80, 25, 15, 0, 0, 4);
        1: load_settings(8, 4, 3, 12, 5, 3);
        2: load_settings(1, 4, 0, 15, 15, 0);
        3: load_settings(127, 31, 15, 0, 0, 15);
        4: load_settings(0, 0, 9, 6, 10, 1);
        5: load_settings($urandom_range(16, 2), $urandom_range(8, 4), $urandom_range(15),
                         $urandom_range(15), $urandom_range(15), $urandom_range(15));
        6: load_settings(80, 25, $urandom_range(15), $urandom_range(15),
                         $urandom_range(15), 15);
        default: load_settings($urandom_range(127), $urandom_range(31), $urandom_range(15),
                               $urandom_range(15), $urandom_range(15), $urandom_range(15));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // hold off mid-phase until the console has answered everything
        if (n == PHASE_WORDS / 2) drain(0);
        random_word();
      end
    end

    drain(WALK_SETTLE);
    $display("covered %0d input words over %0d register settings and four idling patterns",
             words_sent, settings_done);
    $display("%0d output words compared, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
